// ===== hw/rtl/vpvc_pkg.sv =====
// Shared types, codes and the bitplane decode function of the video port interface.
// No dependencies.
`default_nettype none

package vpvc_pkg;

    // port access codes
    localparam logic [1:0] CMD_DATA_READ   = 2'd0;
    localparam logic [1:0] CMD_DATA_WRITE  = 2'd1;
    localparam logic [1:0] CMD_CTRL_WRITE  = 2'd2;
    localparam logic [1:0] CMD_STATUS_READ = 2'd3;

    // second control byte opcodes
    localparam logic [1:0] OP_VRAM_READ  = 2'd0;
    localparam logic [1:0] OP_VRAM_WRITE = 2'd1;
    localparam logic [1:0] OP_REG_WRITE  = 2'd2;
    localparam logic [1:0] OP_CRAM_WRITE = 2'd3;

    localparam logic [3:0] REG_BORDER = 4'd7;

    typedef logic [13:0] vaddr_t;

    // Four plane bytes of one row -> one 32-bit pixel word. Pixel k sits in
    // bits [8k+3 -: 4], plane j lands on bit 8k+3-j.
    function automatic logic [31:0] plane_decode(input logic [31:0] word, input logic hi);
        logic [31:0] r;
        r = '0;
        for (int j = 0; j < 4; j++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                r[8*k+3-j] = hi ? word[8*j+4+k] : word[8*j+k];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/video_port_vram_cram_interface.sv =====
// CPU-side port interface of a tile video chip: address latch, VRAM with
// decoded pattern rows, colour RAM conversion, border register. Uses vpvc_pkg.
`default_nettype none

// One transaction per clock sustained while neither the output stalls nor the
// clearing pass runs; each result passes through the stage-1 registers into the
// output register. VRAM lives in one synchronous word memory (four plane bytes
// per row, registered read), read at accept and written back from stage 1; a
// write-back to the row the next transaction reads is forwarded. After reset a
// clearing pass zeroes the memory row by row, and in_stall stays high until it ends.
module video_port_vram_cram_interface #(
    parameter int VIDEO_BYTES = 16384
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  write_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_byte,
    output logic             pattern_valid,
    output logic [11:0]      pattern_row,
    output logic [31:0]      pattern_left,
    output logic [31:0]      pattern_right,
    output logic             palette_valid,
    output logic [4:0]       palette_index,
    output logic [23:0]      palette_color,
    output logic [3:0]       border_color
);
    import vpvc_pkg::*;

    localparam int ADDR_W = $clog2(VIDEO_BYTES);
    localparam int ROWS   = VIDEO_BYTES / 4;
    localparam int ROW_W  = ADDR_W - 2;

    // architectural state
    vaddr_t            addr_reg, addr_next;
    logic              pending_reg, pending_next;
    logic              cram_sel_reg, cram_sel_next;
    logic [7:0]        latch_reg, latch_next;
    logic [3:0]        border_reg, border_next;
    logic              handheld_reg;
    logic [7:0]        ra_reg, ra_next;

    // clearing pass
    logic              clear_active_reg;
    logic [ROW_W-1:0]  clr_reg;

    // memory
    logic [31:0]       word_mem [ROWS];
    logic [31:0]       rd_data_reg;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [31:0]       wr_data;
    logic              fwd_reg;
    logic [31:0]       fwd_word_reg;

    // stage 1
    logic              s1_valid_reg;
    logic              s1_vram_wr_reg, s1_vram_wr_next;
    logic              s1_ra_load_reg, s1_ra_load_next;
    logic              s1_ra_set_reg, s1_ra_set_next;
    logic              s1_read_out_reg, s1_read_out_next;
    logic [7:0]        s1_byte_reg;
    logic [1:0]        s1_sh_reg, s1_sh_next;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_pal_valid_reg, s1_pal_valid_next;
    logic [4:0]        s1_pal_index_reg, s1_pal_index_next;
    logic [23:0]       s1_pal_color_reg, s1_pal_color_next;
    logic [3:0]        s1_border_reg;

    // output register
    logic              out_valid_reg;
    logic [7:0]        out_read_reg;
    logic              out_pat_valid_reg;
    logic [11:0]       out_pat_row_reg;
    logic [31:0]       out_left_reg;
    logic [31:0]       out_right_reg;
    logic              out_pal_valid_reg;
    logic [4:0]        out_pal_index_reg;
    logic [23:0]       out_pal_color_reg;
    logic [3:0]        out_border_reg;

    logic              accept;
    logic              s1_go;
    vaddr_t            adv_addr;
    logic [31:0]       cur_word;
    logic [31:0]       new_word;
    logic [31:0]       new_left;
    logic [31:0]       new_right;
    logic [7:0]        sel_byte;

    assign cfg_ready = 1'b1;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clear_active_reg || (s1_valid_reg && !s1_go);
    assign accept   = in_valid && !in_stall;

    // address after a data access, wrapped to the memory size
    assign adv_addr = vaddr_t'(addr_reg[ADDR_W-1:0] + ADDR_W'(1));

    // ---------------- stage 0: decode the transaction ----------------
    always_comb
    begin
        addr_next         = addr_reg;
        pending_next      = pending_reg;
        cram_sel_next     = cram_sel_reg;
        latch_next        = latch_reg;
        border_next       = border_reg;
        rd_en             = 1'b0;
        rd_row            = addr_reg[ADDR_W-1:2];
        s1_vram_wr_next   = 1'b0;
        s1_ra_load_next   = 1'b0;
        s1_ra_set_next    = 1'b0;
        s1_read_out_next  = 1'b0;
        s1_sh_next        = addr_reg[1:0];
        s1_pal_valid_next = 1'b0;
        s1_pal_index_next = '0;
        s1_pal_color_next = '0;

        unique case (command)
            CMD_DATA_READ:
            begin
                s1_read_out_next = 1'b1;
                s1_ra_load_next  = 1'b1;
                rd_en            = 1'b1;
                rd_row           = adv_addr[ADDR_W-1:2];
                s1_sh_next       = adv_addr[1:0];
                addr_next        = adv_addr;
                pending_next     = 1'b0;
            end
            CMD_DATA_WRITE:
            begin
                s1_ra_set_next = 1'b1;
                if (!cram_sel_reg)
                begin
                    s1_vram_wr_next = 1'b1;
                    rd_en           = 1'b1;
                end
                else if (handheld_reg)
                begin
                    if (addr_reg[0])
                    begin
                        s1_pal_valid_next = 1'b1;
                        s1_pal_index_next = addr_reg[5:1];
                        s1_pal_color_next = {latch_reg[3:0], 4'h0, latch_reg[7:4], 4'h0,
                                             write_byte[3:0], 4'h0};
                    end
                    else
                    begin
                        latch_next = write_byte;
                    end
                end
                else
                begin
                    s1_pal_valid_next = 1'b1;
                    s1_pal_index_next = addr_reg[4:0];
                    s1_pal_color_next = {write_byte[1:0], 8'h00, write_byte[3:2], 4'h0,
                                         write_byte[5:4], 6'h00};
                end
                addr_next    = adv_addr;
                pending_next = 1'b0;
            end
            CMD_CTRL_WRITE:
            begin
                if (!pending_reg)
                begin
                    addr_next    = {addr_reg[13:8], write_byte};
                    pending_next = 1'b1;
                end
                else
                begin
                    addr_next    = {write_byte[5:0], addr_reg[7:0]};
                    pending_next = 1'b0;
                    unique case (write_byte[7:6])
                        OP_REG_WRITE:
                        begin
                            cram_sel_next = 1'b0;
                            if (write_byte[3:0] == REG_BORDER)
                            begin
                                border_next = addr_reg[3:0];
                            end
                        end
                        OP_VRAM_READ:
                        begin
                            cram_sel_next   = 1'b0;
                            s1_ra_load_next = 1'b1;
                            rd_en           = 1'b1;
                            rd_row          = addr_next[ADDR_W-1:2];
                            s1_sh_next      = addr_next[1:0];
                        end
                        OP_VRAM_WRITE:
                        begin
                            cram_sel_next = 1'b0;
                        end
                        OP_CRAM_WRITE:
                        begin
                            cram_sel_next = 1'b1;
                        end
                        default:
                        begin
                            cram_sel_next = cram_sel_reg;
                        end
                    endcase
                end
            end
            CMD_STATUS_READ:
            begin
                pending_next = 1'b0;
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase
    end

    // ---------------- stage 1: read-modify-write ----------------
    always_comb
    begin
        cur_word = fwd_reg ? fwd_word_reg : rd_data_reg;
        new_word = cur_word;
        new_word[{s1_sh_reg, 3'b000} +: 8] = s1_byte_reg;
        new_left  = plane_decode(new_word, 1'b1);
        new_right = plane_decode(new_word, 1'b0);
        sel_byte  = cur_word[{s1_sh_reg, 3'b000} +: 8];

        ra_next = ra_reg;
        if (s1_go)
        begin
            if (s1_ra_load_reg)
            begin
                ra_next = sel_byte;
            end
            else if (s1_ra_set_reg)
            begin
                ra_next = s1_byte_reg;
            end
        end

        if (clear_active_reg)
        begin
            wr_en   = 1'b1;
            wr_row  = clr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_go && s1_vram_wr_reg;
            wr_row  = s1_row_reg;
            wr_data = new_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_mem[wr_row] <= wr_data;
        end
        if (accept && rd_en)
        begin
            rd_data_reg <= word_mem[rd_row];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg       <= write_byte;
            s1_row_reg        <= rd_row;
            s1_sh_reg         <= s1_sh_next;
            s1_pal_index_reg  <= s1_pal_index_next;
            s1_pal_color_reg  <= s1_pal_color_next;
            s1_border_reg     <= border_next;
            fwd_word_reg      <= new_word;
        end
        if (s1_go)
        begin
            out_read_reg      <= s1_read_out_reg ? ra_reg : 8'h00;
            out_pat_valid_reg <= s1_vram_wr_reg;
            out_pat_row_reg   <= s1_vram_wr_reg ? 12'(s1_row_reg) : 12'h000;
            out_left_reg      <= s1_vram_wr_reg ? new_left : 32'h0;
            out_right_reg     <= s1_vram_wr_reg ? new_right : 32'h0;
            out_pal_valid_reg <= s1_pal_valid_reg;
            out_pal_index_reg <= s1_pal_index_reg;
            out_pal_color_reg <= s1_pal_color_reg;
            out_border_reg    <= s1_border_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg         <= '0;
            pending_reg      <= 1'b0;
            cram_sel_reg     <= 1'b0;
            latch_reg        <= '0;
            border_reg       <= '0;
            handheld_reg     <= 1'b0;
            ra_reg           <= '0;
            clear_active_reg <= 1'b1;
            clr_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            s1_vram_wr_reg   <= 1'b0;
            s1_ra_load_reg   <= 1'b0;
            s1_ra_set_reg    <= 1'b0;
            s1_read_out_reg  <= 1'b0;
            s1_pal_valid_reg <= 1'b0;
            fwd_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                handheld_reg <= cfg_data;
            end
            if (clear_active_reg)
            begin
                clr_reg <= clr_reg + ROW_W'(1);
                if (clr_reg == ROW_W'(ROWS - 1))
                begin
                    clear_active_reg <= 1'b0;
                end
            end
            ra_reg <= ra_next;
            if (accept)
            begin
                addr_reg         <= addr_next;
                pending_reg      <= pending_next;
                cram_sel_reg     <= cram_sel_next;
                latch_reg        <= latch_next;
                border_reg       <= border_next;
                s1_vram_wr_reg   <= s1_vram_wr_next;
                s1_ra_load_reg   <= s1_ra_load_next;
                s1_ra_set_reg    <= s1_ra_set_next;
                s1_read_out_reg  <= s1_read_out_next;
                s1_pal_valid_reg <= s1_pal_valid_next;
                // same-edge write-back to the row being read: memory returns old data
                fwd_reg          <= rd_en && wr_en && !clear_active_reg && (wr_row == rd_row);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_byte     = out_read_reg;
    assign pattern_valid = out_pat_valid_reg;
    assign pattern_row   = out_pat_row_reg;
    assign pattern_left  = out_left_reg;
    assign pattern_right = out_right_reg;
    assign palette_valid = out_pal_valid_reg;
    assign palette_index = out_pal_index_reg;
    assign palette_color = out_pal_color_reg;
    assign border_color  = out_border_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> in_stall)
        else $error("transaction accepted during clearing pass");

    a_single_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_pat_valid_reg && out_pal_valid_reg))
        else $error("pattern and palette result in one transaction");

    a_fwd_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_reg) |-> $past(s1_go && s1_vram_wr_reg))
        else $error("forwarding without a write-back");

    a_pattern_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pat_valid_reg) |-> (out_left_reg == 32'h0 &&
        out_right_reg == 32'h0 && out_pat_row_reg == 12'h000))
        else $error("pattern fields not cleared");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> s1_valid_reg)
        else $error("stage 1 transaction lost while stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/vpvc_port_check.sv =====
// Checker for the video port interface: tracks config and port transactions,
// predicts each result and compares it with the output channel. Uses vpvc_pkg.
module vpvc_port_check #(
    parameter int VIDEO_BYTES = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  write_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_byte,
    input  logic        pattern_valid,
    input  logic [11:0] pattern_row,
    input  logic [31:0] pattern_left,
    input  logic [31:0] pattern_right,
    input  logic        palette_valid,
    input  logic [4:0]  palette_index,
    input  logic [23:0] palette_color,
    input  logic [3:0]  border_color,
    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import vpvc_pkg::*;

    localparam int ROW_COUNT = VIDEO_BYTES / 4;
    localparam logic [13:0] ADDR_MASK = 14'(VIDEO_BYTES - 1);

    typedef struct {
        logic [7:0]  read_byte;
        logic        pat_valid;
        logic [11:0] pat_row;
        logic [31:0] pat_left;
        logic [31:0] pat_right;
        logic        pal_valid;
        logic [4:0]  pal_index;
        logic [23:0] pal_color;
        logic [3:0]  border;
    } port_result_t;

    port_result_t due_port_results[$];

    logic [7:0]  vram_bytes [VIDEO_BYTES];
    logic [63:0] decoded_rows [ROW_COUNT];
    vaddr_t      access_addr;
    logic        second_pending;
    logic        cram_selected;
    logic [7:0]  read_ahead;
    logic [7:0]  color_latch;
    logic [3:0]  border_index;
    logic        handheld;

    initial
    begin
        errors = 0;
        outstanding = 0;
        for (int i = 0; i < VIDEO_BYTES; i++)
            vram_bytes[i] = '0;
        for (int i = 0; i < ROW_COUNT; i++)
            decoded_rows[i] = '0;
    end

    // one plane bit per pixel: nibble bit k goes to bit 8k+3
    function automatic logic [31:0] spread_nibble(input logic [3:0] n);
        logic [31:0] r;
        r = '0;
        for (int k = 0; k < 4; k++)
            r[8*k+3] = n[k];
        return r;
    endfunction

    function automatic vaddr_t next_addr(input vaddr_t a);
        return (a + 14'd1) & ADDR_MASK;
    endfunction

    task automatic predict_access(input logic [1:0] cmd, input logic [7:0] b,
                                  output port_result_t res);
        vaddr_t      a;
        logic [1:0]  sh;
        logic [11:0] row;
        logic [31:0] keep;
        logic [31:0] left;
        logic [31:0] right;
        logic [15:0] rgb;
        logic [23:0] c;
        logic [7:0]  first;
        logic [1:0]  op;
        res = '{default: '0};
        case (cmd)
            CMD_DATA_READ:
            begin
                res.read_byte = read_ahead;
                access_addr = next_addr(access_addr);
                read_ahead = vram_bytes[access_addr & ADDR_MASK];
                second_pending = 1'b0;
            end
            CMD_DATA_WRITE:
            begin
                if (!cram_selected)
                begin
                    a = access_addr & ADDR_MASK;
                    sh = a[1:0];
                    row = 12'(a >> 2) & 12'(ROW_COUNT - 1);
                    keep = ~(32'h0808_0808 >> sh);
                    left = decoded_rows[row][63:32];
                    right = decoded_rows[row][31:0];
                    vram_bytes[a] = b;
                    left = (left & keep) | (spread_nibble(b[7:4]) >> sh);
                    right = (right & keep) | (spread_nibble(b[3:0]) >> sh);
                    decoded_rows[row] = {left, right};
                    res.pat_valid = 1'b1;
                    res.pat_row = row;
                    res.pat_left = left;
                    res.pat_right = right;
                end
                else if (handheld)
                begin
                    // even address only fills the low-byte latch
                    if (access_addr[0])
                    begin
                        rgb = {b, color_latch};
                        c = '0;
                        c[23:20] = rgb[3:0];
                        c[15:12] = rgb[7:4];
                        c[7:4] = rgb[11:8];
                        res.pal_valid = 1'b1;
                        res.pal_index = access_addr[5:1];
                        res.pal_color = c;
                    end
                    else
                    begin
                        color_latch = b;
                    end
                end
                else
                begin
                    c = '0;
                    c[23:22] = b[1:0];
                    c[13:12] = b[3:2];
                    c[7:6] = b[5:4];
                    res.pal_valid = 1'b1;
                    res.pal_index = access_addr[4:0];
                    res.pal_color = c;
                end
                access_addr = next_addr(access_addr);
                second_pending = 1'b0;
                read_ahead = b;
            end
            CMD_CTRL_WRITE:
            begin
                if (!second_pending)
                begin
                    access_addr = {access_addr[13:8], b};
                    second_pending = 1'b1;
                end
                else
                begin
                    first = access_addr[7:0];
                    op = b[7:6];
                    access_addr = {b[5:0], first};
                    case (op)
                        OP_REG_WRITE:
                        begin
                            cram_selected = 1'b0;
                            if (b[3:0] == REG_BORDER)
                                border_index = first[3:0];
                        end
                        OP_VRAM_READ:
                        begin
                            cram_selected = 1'b0;
                            read_ahead = vram_bytes[access_addr & ADDR_MASK];
                        end
                        default:
                            cram_selected = (op == OP_CRAM_WRITE);
                    endcase
                    second_pending = 1'b0;
                end
            end
            default:
                second_pending = 1'b0;
        endcase
        res.border = border_index;
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 50)
            $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        port_result_t res;
        port_result_t want;
        if (!rst_n)
        begin
            access_addr = '0;
            second_pending = 1'b0;
            cram_selected = 1'b0;
            read_ahead = '0;
            color_latch = '0;
            border_index = '0;
            handheld = 1'b0;
            due_port_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_port_results.size() == 0)
                begin
                    report_mismatch("result transaction with nothing outstanding");
                end
                else
                begin
                    want = due_port_results.pop_front();
                    check_field("read_byte", 32'(read_byte), 32'(want.read_byte));
                    check_field("pattern_valid", 32'(pattern_valid), 32'(want.pat_valid));
                    check_field("pattern_row", 32'(pattern_row), 32'(want.pat_row));
                    check_field("pattern_left", pattern_left, want.pat_left);
                    check_field("pattern_right", pattern_right, want.pat_right);
                    check_field("palette_valid", 32'(palette_valid), 32'(want.pal_valid));
                    check_field("palette_index", 32'(palette_index), 32'(want.pal_index));
                    check_field("palette_color", 32'(palette_color), 32'(want.pal_color));
                    check_field("border_color", 32'(border_color), 32'(want.border));
                end
            end
            if (cfg_valid && cfg_ready)
                handheld = cfg_data;
            if (in_valid && !in_stall)
            begin
                predict_access(command, write_byte, res);
                due_port_results.push_back(res);
            end
            outstanding <= due_port_results.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the video port interface: clock, reset, port and config
// stimulus with random gaps and stalls, verdict. Uses vpvc_pkg and vpvc_port_check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vpvc_pkg::*;

    localparam int VIDEO_BYTES = 16384;
    localparam int PHASE_ITEMS = 370;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_STATUS_READ;
    logic [7:0]  write_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_byte;
    logic        pattern_valid;
    logic [11:0] pattern_row;
    logic [31:0] pattern_left;
    logic [31:0] pattern_right;
    logic        palette_valid;
    logic [4:0]  palette_index;
    logic [23:0] palette_color;
    logic [3:0]  border_color;

    int errors;
    int outstanding;
    int sent_count = 0;
    bit quiet = 1'b0;   // no gaps or stalls while set

    always #1 clk = ~clk;

    video_port_vram_cram_interface #(
        .VIDEO_BYTES(VIDEO_BYTES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .write_byte(write_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_byte(read_byte),
        .pattern_valid(pattern_valid),
        .pattern_row(pattern_row),
        .pattern_left(pattern_left),
        .pattern_right(pattern_right),
        .palette_valid(palette_valid),
        .palette_index(palette_index),
        .palette_color(palette_color),
        .border_color(border_color)
    );

    vpvc_port_check #(
        .VIDEO_BYTES(VIDEO_BYTES)
    ) u_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .write_byte(write_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_byte(read_byte),
        .pattern_valid(pattern_valid),
        .pattern_row(pattern_row),
        .pattern_left(pattern_left),
        .pattern_right(pattern_right),
        .palette_valid(palette_valid),
        .palette_index(palette_index),
        .palette_color(palette_color),
        .border_color(border_color),
        .errors(errors),
        .outstanding(outstanding)
    );

    // one port transaction; returns in the step of the accepting edge
    task automatic port_access(input logic [1:0] cmd, input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        write_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // status read first so the control latch starts clean
    task automatic set_address(input vaddr_t addr, input logic [1:0] op);
        port_access(CMD_STATUS_READ, 8'($urandom));
        port_access(CMD_CTRL_WRITE, addr[7:0]);
        port_access(CMD_CTRL_WRITE, {op, addr[13:8]});
    endtask

    // the count seen at the accepting edge still lacks that transaction
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic vaddr_t pick_address();
        // a small window half of the time so rows get merged repeatedly
        if ($urandom_range(0, 1))
            return vaddr_t'($urandom_range(0, 255));
        return vaddr_t'($urandom_range(0, VIDEO_BYTES - 1));
    endfunction

    task automatic run_random(input int items);
        int stop_at;
        int kind;
        int len;
        stop_at = sent_count + items;
        while (sent_count < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                set_address(pick_address(), OP_VRAM_WRITE);
                len = $urandom_range(1, 8);
                repeat (len) port_access(CMD_DATA_WRITE, 8'($urandom));
            end
            else if (kind < 55)
            begin
                set_address(pick_address(), OP_VRAM_READ);
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    if ($urandom_range(0, 4) == 0)
                        port_access(CMD_DATA_WRITE, 8'($urandom));
                    else
                        port_access(CMD_DATA_READ, 8'($urandom));
                end
            end
            else if (kind < 70)
            begin
                set_address(pick_address(), OP_CRAM_WRITE);
                len = $urandom_range(1, 8);
                repeat (len) port_access(CMD_DATA_WRITE, 8'($urandom));
            end
            else if (kind < 80)
            begin
                port_access(CMD_STATUS_READ, 8'($urandom));
                port_access(CMD_CTRL_WRITE, 8'($urandom));
                if ($urandom_range(0, 1))
                    port_access(CMD_CTRL_WRITE, {OP_REG_WRITE, 2'($urandom), REG_BORDER});
                else
                    port_access(CMD_CTRL_WRITE, {OP_REG_WRITE, 6'($urandom)});
            end
            else
            begin
                len = $urandom_range(1, 4);
                repeat (len) port_access(2'($urandom), 8'($urandom));
            end
        end
    endtask

    // receiver: random stall before each result transaction
    initial
    begin
        int n;
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 10);
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #1_000_000;
        $display("FAIL video_port_vram_cram_interface");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(1'b0);

        // directed: latch, plane merge at every byte lane, wrap, registers, colors
        port_access(CMD_STATUS_READ, 8'hff);
        set_address(14'h0000, OP_VRAM_WRITE);
        port_access(CMD_DATA_WRITE, 8'hff);
        port_access(CMD_DATA_WRITE, 8'h00);
        port_access(CMD_DATA_WRITE, 8'ha5);
        port_access(CMD_DATA_WRITE, 8'h5a);
        set_address(14'h0000, OP_VRAM_READ);
        port_access(CMD_DATA_READ, 8'h00);
        port_access(CMD_DATA_READ, 8'hff);
        set_address(14'h3fff, OP_VRAM_WRITE);
        port_access(CMD_DATA_WRITE, 8'h81);
        port_access(CMD_DATA_READ, 8'h00);
        port_access(CMD_CTRL_WRITE, 8'h0f);
        port_access(CMD_CTRL_WRITE, {OP_REG_WRITE, 2'b00, REG_BORDER});
        port_access(CMD_CTRL_WRITE, 8'h03);
        port_access(CMD_CTRL_WRITE, {OP_REG_WRITE, 6'h0f});
        // a data access drops the half-written control pair
        port_access(CMD_CTRL_WRITE, 8'h12);
        port_access(CMD_DATA_READ, 8'h00);
        set_address(14'h001f, OP_CRAM_WRITE);
        port_access(CMD_DATA_WRITE, 8'hff);
        port_access(CMD_DATA_WRITE, 8'h00);
        port_access(CMD_DATA_WRITE, 8'h3c);
        drain();

        write_mode(1'b1);
        set_address(14'h003e, OP_CRAM_WRITE);
        port_access(CMD_DATA_WRITE, 8'h21);
        port_access(CMD_DATA_WRITE, 8'h43);
        port_access(CMD_DATA_WRITE, 8'hff);
        port_access(CMD_DATA_WRITE, 8'hff);
        port_access(CMD_DATA_WRITE, 8'h00);
        run_random(PHASE_ITEMS);
        drain();

        write_mode(1'b0);
        quiet = 1'b1;
        run_random(PHASE_ITEMS);
        drain();
        quiet = 1'b0;

        write_mode(1'b1);
        run_random(PHASE_ITEMS);
        drain();

        write_mode(1'b0);
        run_random(PHASE_ITEMS);
        in_valid <= 1'b0;
        @(posedge clk);

        for (int i = 0; i < 20000 && outstanding != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("PASS video_port_vram_cram_interface");
        else
            $display("FAIL video_port_vram_cram_interface");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vpvc_pkg.sv
hw/rtl/video_port_vram_cram_interface.sv
tb/sv/vpvc_port_check.sv
tb/sv/tb.sv
